@@ sv/sample_volume_pack_ring_writer_assert.svh @@
// Assertion macros shared by the volume/pack/ring writer modules.
// Expects clk and arst_n in scope at the point of use.
`ifndef SAMPLE_VOLUME_PACK_RING_WRITER_ASSERT_SVH
`define SAMPLE_VOLUME_PACK_RING_WRITER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SVPR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define SVPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/svpr_pkg.sv @@
// Shared types and constants for the volume/pack/ring writer.
// No dependencies; every other file but the assertion header imports this package.
package svpr_pkg;

	// default parameter values
	localparam int MAX_FRAMES_DEF       = 65536;
	localparam int SAMPLE_FRAC_BITS_DEF = 20;

	// fixed field widths
	localparam int SAMPLE_W    = 24;
	localparam int GAIN_W      = 16;
	localparam int FRAMES_W    = 17;
	localparam int ADDR_W      = 17;
	localparam int PCM_W       = 16;
	localparam int START_W     = 32;
	localparam int CFG_DATA_W  = 17;
	localparam int PROD_W      = SAMPLE_W + GAIN_W;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_SAMPLE_WIDTH_MODE = 2'd0,
		CFG_CHANNEL_COUNT     = 2'd1,
		CFG_BUFFER_FRAMES     = 2'd2,
		CFG_VOLUME_GAIN       = 2'd3
	} cfg_idx_t;

	// register reset values and codes
	localparam logic                RST_WIDTH_MODE = 1'b0;
	localparam logic [1:0]          RST_CHANNELS   = 2'd2;
	localparam logic [FRAMES_W-1:0] RST_FRAMES     = 17'd16384;
	localparam logic [GAIN_W-1:0]   RST_GAIN       = 16'd22938;
	localparam logic [1:0]          CHAN_MONO      = 2'd1;
	localparam logic                MODE_PCM8      = 1'b1;

	// saturation limits
	localparam logic [15:0] PCM16_MAX     = 16'h7fff;
	localparam logic [15:0] PCM16_MIN_MAG = 16'h8000;
	localparam logic [7:0]  PCM8_MAX      = 8'h7f;
	localparam logic [7:0]  PCM8_MIN_MAG  = 8'h80;
	localparam logic [7:0]  PCM8_OFFSET   = 8'd128;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic div_start;
		logic idx_load;
		logic mul_en;
		logic mul_sel;
		logic emit;
		logic emit_last;
	} svpr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic div_done;
		logic stereo;
	} svpr_stat_t;

endpackage

@@ sv/svpr_in_if.sv @@
// Input channel: one stereo sample pair plus block-start information.
// Depends on svpr_pkg for field widths.
interface svpr_in_if;
	import svpr_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       first_of_block;
	logic [START_W-1:0]         start_frame;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;

	modport source (output valid, first_of_block, start_frame, left_sample, right_sample,
		input ready);
	modport sink (input valid, first_of_block, start_frame, left_sample, right_sample,
		output ready);
endinterface

@@ sv/svpr_out_if.sv @@
// Output channel: one PCM sample with its ring buffer address.
// Depends on svpr_pkg for field widths.
interface svpr_out_if;
	import svpr_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] write_address;
	logic [PCM_W-1:0]  pcm_value;
	logic              last_of_item;

	modport source (output valid, write_address, pcm_value, last_of_item, input ready);
	modport sink (input valid, write_address, pcm_value, last_of_item, output ready);
endinterface

@@ sv/svpr_mod_unit.sv @@
// Restoring remainder unit: start_frame mod frames, one quotient bit per cycle.
// Depends on svpr_pkg and the assertion header.
`include "sample_volume_pack_ring_writer_assert.svh"
module svpr_mod_unit #(
	parameter int MAX_FRAMES = svpr_pkg::MAX_FRAMES_DEF,
	localparam int FW = $clog2(MAX_FRAMES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [svpr_pkg::START_W-1:0] dividend,
	input  logic [FW-1:0]               divisor,
	output logic                        done,
	output logic [FW-1:0]               rem
);
	import svpr_pkg::*;

	localparam int CW = $clog2(START_W);

	logic               busy_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [START_W-1:0] dvd_q;
	logic [FW-1:0]      rem_q;
	logic [FW-1:0]      dsr_q;

	logic [FW:0]   trial;
	logic [FW:0]   diff;
	logic [FW-1:0] rem_nxt;

	// one shift-and-subtract step
	always_comb begin
		trial   = {rem_q, dvd_q[START_W-1]};
		diff    = trial - {1'b0, dsr_q};
		rem_nxt = (trial >= {1'b0, dsr_q}) ? diff[FW-1:0] : trial[FW-1:0];
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(START_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[START_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	`SVPR_ASSERT_NOW(a_no_restart, start, !busy_q, "remainder unit restarted while busy")
	`SVPR_ASSERT_NOW(a_rem_range, done_q, rem_q < dsr_q, "remainder not below divisor")
endmodule

@@ sv/svpr_ctrl.sv @@
// Sequencing controller: accept, optional remainder, multiply and emit per sample.
// Depends on svpr_pkg and the assertion header.
`include "sample_volume_pack_ring_writer_assert.svh"
module svpr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_first,
	output logic                 in_ready,
	input  svpr_pkg::svpr_stat_t stat,
	output svpr_pkg::svpr_cmd_t  cmd
);
	import svpr_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_EMIT} state_t;

	state_t state_q;
	logic   sel_q;
	logic   last_now;
	logic   accept_ok;
	logic   accept;

	// command decode
	always_comb begin
		last_now      = !(stat.stereo && !sel_q);
		accept_ok     = (state_q == S_IDLE) ||
			(state_q == S_EMIT && stat.out_free && last_now);
		accept        = accept_ok && in_valid;
		in_ready      = accept_ok;
		cmd.load_in   = accept;
		cmd.div_start = accept && in_first;
		cmd.idx_load  = (state_q == S_DIV) && stat.div_done;
		cmd.mul_en    = (state_q == S_MUL);
		cmd.mul_sel   = sel_q;
		cmd.emit      = (state_q == S_EMIT) && stat.out_free;
		cmd.emit_last = last_now;
	end

	// state and sample select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						sel_q   <= 1'b0;
						state_q <= in_first ? S_DIV : S_MUL;
					end
				end
				S_DIV: begin
					if (stat.div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (stat.out_free) begin
						if (!last_now) begin
							sel_q   <= 1'b1;
							state_q <= S_MUL;
						end else if (accept) begin
							sel_q   <= 1'b0;
							state_q <= in_first ? S_DIV : S_MUL;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SVPR_ASSERT_NOW(a_ready_state, in_ready, state_q == S_IDLE || state_q == S_EMIT,
		"ready raised while an item is in progress")
	`SVPR_ASSERT_NOW(a_div_on_accept, cmd.div_start, in_valid && in_ready,
		"remainder started without an input transfer")
	`SVPR_ASSERT_NEXT(a_mul_then_emit, cmd.mul_en, state_q == S_EMIT,
		"multiply not followed by emit")
endmodule

@@ sv/svpr_datapath.sv @@
// Datapath: config registers, sample scaling and saturation, ring index, output register.
// Depends on svpr_pkg, svpr_mod_unit and the assertion header.
`include "sample_volume_pack_ring_writer_assert.svh"
module svpr_datapath #(
	parameter int MAX_FRAMES       = svpr_pkg::MAX_FRAMES_DEF,
	parameter int SAMPLE_FRAC_BITS = svpr_pkg::SAMPLE_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  svpr_pkg::cfg_idx_t                  cfg_index,
	input  logic [svpr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  svpr_pkg::svpr_cmd_t                 cmd,
	output svpr_pkg::svpr_stat_t                stat,
	input  logic [svpr_pkg::START_W-1:0]        in_start_frame,
	input  logic signed [svpr_pkg::SAMPLE_W-1:0] in_left,
	input  logic signed [svpr_pkg::SAMPLE_W-1:0] in_right,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [svpr_pkg::ADDR_W-1:0]         out_addr,
	output logic [svpr_pkg::PCM_W-1:0]          out_pcm,
	output logic                                out_last
);
	import svpr_pkg::*;

	localparam int FW = $clog2(MAX_FRAMES + 1);
	localparam int IW = $clog2(2 * MAX_FRAMES);

	// configuration registers
	logic                mode_q;
	logic [1:0]          chan_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [GAIN_W-1:0]   gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= RST_WIDTH_MODE;
			chan_q   <= RST_CHANNELS;
			frames_q <= RST_FRAMES;
			gain_q   <= RST_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SAMPLE_WIDTH_MODE: mode_q   <= cfg_data[0];
				CFG_CHANNEL_COUNT:     chan_q   <= cfg_data[1:0];
				CFG_BUFFER_FRAMES:     frames_q <= cfg_data[FRAMES_W-1:0];
				CFG_VOLUME_GAIN:       gain_q   <= cfg_data[GAIN_W-1:0];
				default:               mode_q   <= mode_q;
			endcase
		end
	end

	// effective frame count and buffer size
	logic          stereo;
	logic [31:0]   bf_ext;
	logic [31:0]   frames_eff32;
	logic [FW-1:0] frames_eff;
	logic [IW:0]   tot1;
	logic [IW:0]   total;

	always_comb begin
		stereo       = (chan_q != CHAN_MONO);
		bf_ext       = 32'(frames_q);
		frames_eff32 = (frames_q == '0) ? 32'd1 :
			(bf_ext > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES) : bf_ext;
		frames_eff   = frames_eff32[FW-1:0];
		tot1         = (IW+1)'(frames_eff);
		total        = stereo ? {tot1[IW-1:0], 1'b0} : tot1;
	end

	// start_frame mod frames
	logic          div_done;
	logic [FW-1:0] div_rem;

	svpr_mod_unit #(.MAX_FRAMES(MAX_FRAMES)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (in_start_frame),
		.divisor  (frames_eff),
		.done     (div_done),
		.rem      (div_rem)
	);

	// captured samples
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			left_q  <= in_left;
			right_q <= in_right;
		end
	end

	// volume multiply, registered
	logic signed [SAMPLE_W:0]   samp_ext;
	logic signed [SAMPLE_W:0]   gain_ext;
	logic signed [2*SAMPLE_W+1:0] prod_full;
	logic signed [PROD_W-1:0]   prod_q;

	always_comb begin
		samp_ext  = cmd.mul_sel ? (SAMPLE_W+1)'(right_q) : (SAMPLE_W+1)'(left_q);
		gain_ext  = $signed((SAMPLE_W+1)'(gain_q));
		prod_full = samp_ext * gain_ext;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= prod_full[PROD_W-1:0];
		end
	end

	// truncate toward zero, saturate and pack
	logic              neg;
	logic [PROD_W-1:0] mag;
	logic [PROD_W-1:0] q16;
	logic [PROD_W-1:0] q8;
	logic [15:0]       q16_lo;
	logic [7:0]        q8_lo;
	logic [15:0]       pcm16;
	logic [7:0]        pcm8;
	logic [PCM_W-1:0]  pcm;

	always_comb begin
		neg    = prod_q[PROD_W-1];
		mag    = neg ? $unsigned(-prod_q) : $unsigned(prod_q);
		q16    = mag >> SAMPLE_FRAC_BITS;
		q8     = mag >> (SAMPLE_FRAC_BITS + 8);
		q16_lo = q16[15:0];
		q8_lo  = q8[7:0];
		if (neg) begin
			pcm16 = (q16 > PROD_W'(PCM16_MIN_MAG)) ? PCM16_MIN_MAG : -q16_lo;
			pcm8  = (q8 > PROD_W'(PCM8_MIN_MAG)) ? (PCM8_OFFSET - PCM8_MIN_MAG) :
				(PCM8_OFFSET - q8_lo);
		end else begin
			pcm16 = (q16 > PROD_W'(PCM16_MAX)) ? PCM16_MAX : q16_lo;
			pcm8  = (q8 > PROD_W'(PCM8_MAX)) ? (PCM8_MAX + PCM8_OFFSET) :
				(q8_lo + PCM8_OFFSET);
		end
		pcm = (mode_q == MODE_PCM8) ? {8'd0, pcm8} : pcm16;
	end

	// ring index: wrap before use, advance after
	logic [IW-1:0] idx_q;
	logic [IW:0]   idx_wrap;
	logic [IW:0]   idx_inc;
	logic [IW-1:0] idx_next;
	logic [IW-1:0] rem_ext;
	logic [31:0]   addr_ext;

	always_comb begin
		idx_wrap = ({1'b0, idx_q} >= total) ? '0 : {1'b0, idx_q};
		idx_inc  = idx_wrap + (IW+1)'(1);
		idx_next = (idx_inc >= total) ? '0 : idx_inc[IW-1:0];
		rem_ext  = IW'(div_rem);
		addr_ext = 32'(idx_wrap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_load) begin
			idx_q <= stereo ? {rem_ext[IW-2:0], 1'b0} : rem_ext;
		end else if (cmd.emit) begin
			idx_q <= idx_next;
		end
	end

	// output register
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [PCM_W-1:0]  out_pcm_q;
	logic              out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_addr_q <= addr_ext[ADDR_W-1:0];
			out_pcm_q  <= pcm;
			out_last_q <= cmd.emit_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_addr      = out_addr_q;
	assign out_pcm       = out_pcm_q;
	assign out_last      = out_last_q;
	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.div_done = div_done;
	assign stat.stereo   = stereo;

	`SVPR_ASSERT_NEXT(a_idx_in_ring, cmd.emit, {1'b0, idx_q} < $past(total),
		"ring index left the buffer after a write")
endmodule

@@ sv/sample_volume_pack_ring_writer.sv @@
// Path: a captured input pair passes the multiply register, then the output register,
// which waits while a result is pending; a block start first runs the 32-step
// start_frame mod frames unit. Each item gives one result per channel (multiply, then
// saturate into the output register); a new item is taken when idle or with the last emit.
// Reset (arst_n low, asynchronous): registers return to their defaults, ring index 0,
// no result pending.
module sample_volume_pack_ring_writer #(
	parameter int MAX_FRAMES       = svpr_pkg::MAX_FRAMES_DEF,
	parameter int SAMPLE_FRAC_BITS = svpr_pkg::SAMPLE_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  svpr_pkg::cfg_idx_t              cfg_index,
	input  logic [svpr_pkg::CFG_DATA_W-1:0] cfg_data,
	svpr_in_if.sink                         in_ch,
	svpr_out_if.source                      out_ch
);
	import svpr_pkg::*;

	svpr_cmd_t  cmd;
	svpr_stat_t stat;

	// sequencing
	svpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_first (in_ch.first_of_block),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic, addressing and output register
	svpr_datapath #(
		.MAX_FRAMES       (MAX_FRAMES),
		.SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.stat           (stat),
		.in_start_frame (in_ch.start_frame),
		.in_left        (in_ch.left_sample),
		.in_right       (in_ch.right_sample),
		.out_ready      (out_ch.ready),
		.out_valid      (out_ch.valid),
		.out_addr       (out_ch.write_address),
		.out_pcm        (out_ch.pcm_value),
		.out_last       (out_ch.last_of_item)
	);
endmodule

@@ tb/sample_volume_pack_ring_writer_tb.sv @@
// Self-checking testbench for sample_volume_pack_ring_writer: volume scaling, PCM packing
// and ring buffer addressing, predicted per input pair and checked per output write.
// Depends on svpr_pkg, svpr_in_if, svpr_out_if and the RTL top level.
module sample_volume_pack_ring_writer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import svpr_pkg::*;

	localparam int STALL_LIMIT = 4000;  // cycles with no transfer before giving up
	localparam int END_PAUSE   = 40;    // idle time after the final drain
	localparam int HOLD_CYCLES = 400;   // long output stall for the pressure test
	localparam int PRINT_MAX   = 50;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PCM_W-1:0]  pcm;
		logic              last;
	} pcm_write_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	svpr_in_if  in_ch();
	svpr_out_if out_ch();

	sample_volume_pack_ring_writer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// predictor copy of registers and ring position
	logic                cur_width_mode;
	logic [1:0]          cur_channels;
	logic [FRAMES_W-1:0] cur_frames;
	logic [GAIN_W-1:0]   cur_gain;
	int unsigned         ring_pos;

	pcm_write_t pending_writes[$];

	int mismatches       = 0;
	int writes_checked   = 0;
	int items_sent       = 0;
	int settings_applied = 0;
	int src_idle_pct     = 0;
	int snk_idle_pct     = 0;
	int hold_left        = 0;
	int stall_cycles     = 0;

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_MAX)
			$display("%0t ns mismatch: %s", $realtime, msg);
	endtask

	// scale by volume, truncate toward zero, saturate and pack
	function automatic logic [PCM_W-1:0] pack_pcm(input logic signed [SAMPLE_W-1:0] s);
		logic signed [PROD_W:0] prod;
		logic [PROD_W:0]        mag;
		logic [PROD_W:0]        q;
		logic [PCM_W-1:0]       res;
		prod = (PROD_W+1)'(s) * (PROD_W+1)'($signed({1'b0, cur_gain}));
		mag = prod[PROD_W] ? -prod : prod;
		if (cur_width_mode == MODE_PCM8) begin
			q = mag >> (SAMPLE_FRAC_BITS_DEF + 8);
			if (prod[PROD_W])
				res = (q >= PCM8_MIN_MAG) ? '0 : {8'h00, PCM8_OFFSET - q[7:0]};
			else
				res = (q >= PCM8_MAX) ? {8'h00, PCM8_MAX + PCM8_OFFSET}
					: {8'h00, PCM8_OFFSET + q[7:0]};
		end else begin
			q = mag >> SAMPLE_FRAC_BITS_DEF;
			if (prod[PROD_W])
				res = (q >= PCM16_MIN_MAG) ? PCM16_MIN_MAG : -q[15:0];
			else
				res = (q >= PCM16_MAX) ? PCM16_MAX : q[15:0];
		end
		return res;
	endfunction

	// expected ring writes for one accepted pair
	function automatic void predict_writes(input logic first, input logic [START_W-1:0] sf,
		input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
		int unsigned ch;
		int unsigned frames;
		int unsigned total;
		pcm_write_t  w;
		ch = (cur_channels == CHAN_MONO) ? 1 : 2;
		frames = 32'(cur_frames);
		if (frames < 1)
			frames = 1;
		if (frames > MAX_FRAMES_DEF)
			frames = MAX_FRAMES_DEF;
		total = frames * ch;
		if (first)
			ring_pos = (sf % frames) * ch;
		for (int unsigned k = 0; k < ch; k++) begin
			// stale index after a shrink goes back to the ring start
			if (ring_pos >= total)
				ring_pos = 0;
			w.addr = ring_pos[ADDR_W-1:0];
			w.pcm = pack_pcm((k == 0) ? l : r);
			w.last = (k + 1 == ch);
			pending_writes.push_back(w);
			ring_pos++;
			if (ring_pos >= total)
				ring_pos = 0;
		end
	endfunction

	// offer one pair, with random sender gaps, and predict on transfer
	task automatic send_pair(input logic first, input logic [START_W-1:0] sf,
		input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.first_of_block = first;
		in_ch.start_frame = sf;
		in_ch.left_sample = l;
		in_ch.right_sample = r;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		predict_writes(first, sf, l, r);
		items_sent++;
		@(negedge clk);
	endtask

	// stop offering and wait for every predicted write
	task automatic drain_block();
		in_ch.valid = 1'b0;
		while (pending_writes.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_SAMPLE_WIDTH_MODE: cur_width_mode = data[0];
			CFG_CHANNEL_COUNT:     cur_channels = data[1:0];
			CFG_BUFFER_FRAMES:     cur_frames = data;
			CFG_VOLUME_GAIN:       cur_gain = data[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	// all four registers, junk in the unused upper bits
	task automatic apply_setting(input logic w, input logic [1:0] ch,
		input logic [FRAMES_W-1:0] frames, input logic [GAIN_W-1:0] gain);
		logic [31:0] pad;
		pad = $urandom;
		drain_block();
		write_reg(CFG_SAMPLE_WIDTH_MODE, {pad[15:0], w});
		write_reg(CFG_CHANNEL_COUNT, {pad[30:16], ch});
		write_reg(CFG_BUFFER_FRAMES, frames);
		write_reg(CFG_VOLUME_GAIN, {pad[31], gain});
		settings_applied++;
	endtask

	task automatic choose_random_setting();
		logic                w;
		logic [1:0]          ch;
		logic [FRAMES_W-1:0] frames;
		logic [GAIN_W-1:0]   gain;
		w = 1'($urandom_range(1));
		case ($urandom_range(9))
			0:       ch = 2'd0;
			1:       ch = 2'd3;
			2, 3, 4: ch = CHAN_MONO;
			default: ch = 2'd2;
		endcase
		// mostly short rings so wraps are frequent
		case ($urandom_range(19))
			0:       frames = '0;
			1:       frames = 17'h10000;
			2:       frames = 17'h1ffff;
			3:       frames = FRAMES_W'($urandom_range(17'h10001, 17'h1ffff));
			4:       frames = FRAMES_W'($urandom);
			default: frames = FRAMES_W'($urandom_range(1, 48));
		endcase
		case ($urandom_range(9))
			0:       gain = '0;
			1:       gain = 16'hffff;
			2:       gain = 16'h8000;
			default: gain = GAIN_W'($urandom);
		endcase
		apply_setting(w, ch, frames, gain);
	endtask

	// magnitudes spread over all scales so both saturation edges get hit
	function automatic logic [SAMPLE_W-1:0] rand_sample();
		logic [31:0]         raw;
		logic [SAMPLE_W-1:0] mag;
		logic [SAMPLE_W-1:0] s;
		raw = $urandom;
		case ($urandom_range(9))
			0: s = 24'h7fffff;
			1: s = 24'h800000;
			2: s = raw[SAMPLE_W-1:0];
			default: begin
				mag = raw[SAMPLE_W-1:0] >> $urandom_range(23);
				s = raw[31] ? -mag : mag;
			end
		endcase
		return s;
	endfunction

	function automatic logic [START_W-1:0] rand_start_frame();
		logic [START_W-1:0] sf;
		case ($urandom_range(9))
			0:       sf = '1;
			1:       sf = '0;
			2:       sf = $urandom_range(200);
			default: sf = $urandom;
		endcase
		return sf;
	endfunction

	// reset register values, block starts, sample extremes
	task automatic test_reset_defaults();
		send_pair(1'b1, 32'd5, 24'h7fffff, 24'h800000);
		send_pair(1'b0, 32'd0, 24'h000000, 24'hffffff);
		send_pair(1'b1, 32'hffffffff, 24'h000001, 24'h0a5a5a);
	endtask

	// 16-bit packing at gain extremes, truncation toward zero
	task automatic test_pcm16_gain();
		apply_setting(1'b0, 2'd2, 17'd64, 16'hffff);
		send_pair(1'b1, 32'd3, 24'h7fffff, 24'h800000);
		send_pair(1'b0, 32'd0, 24'h100000, 24'hf00000);
		apply_setting(1'b0, 2'd2, 17'd64, 16'h8000);
		send_pair(1'b0, 32'd0, 24'hffffff, 24'h00001f);
		send_pair(1'b0, 32'd0, 24'h0fffff, 24'hf00001);
		apply_setting(1'b0, 2'd2, 17'd64, 16'h0000);
		send_pair(1'b0, 32'd0, 24'h7fffff, 24'h800000);
	endtask

	// 8-bit offset packing and its saturation edges
	task automatic test_pcm8();
		apply_setting(MODE_PCM8, 2'd2, 17'd64, 16'h8000);
		send_pair(1'b1, 32'd10, 24'h100000, 24'hf00000);
		send_pair(1'b0, 32'd0, 24'h7fffff, 24'h800000);
		send_pair(1'b0, 32'd0, 24'hffffff, 24'h000000);
	endtask

	// mono: left only, ring of 5 wraps
	task automatic test_mono();
		apply_setting(1'b0, CHAN_MONO, 17'd5, 16'd40000);
		send_pair(1'b1, 32'd7, 24'h123456, 24'h654321);
		send_pair(1'b0, 32'd0, 24'hedcba9, 24'h000000);
		send_pair(1'b0, 32'd0, 24'h400000, 24'h7fffff);
	endtask

	// channel codes 0 and 3 behave as stereo
	task automatic test_odd_channels();
		apply_setting(1'b0, 2'd0, 17'd3, 16'd30000);
		send_pair(1'b1, 32'd2, 24'h200000, 24'he00000);
		apply_setting(MODE_PCM8, 2'd3, 17'd3, 16'd50000);
		send_pair(1'b1, 32'd4, 24'h300000, 24'hd00000);
	endtask

	// frame count below 1 and above the maximum, top of the address range
	task automatic test_frame_clamp();
		apply_setting(1'b0, 2'd2, 17'd0, 16'd22938);
		send_pair(1'b1, 32'd12345, 24'h0c0000, 24'hf40000);
		apply_setting(1'b0, 2'd2, 17'h10000, 16'd22938);
		send_pair(1'b1, 32'hffffffff, 24'h010000, 24'hff0000);
		send_pair(1'b0, 32'd0, 24'h020000, 24'hfe0000);
		apply_setting(1'b0, 2'd2, 17'h1ffff, 16'd22938);
		send_pair(1'b1, 32'hffffffff, 24'h030000, 24'hfd0000);
	endtask

	// ring shrunk mid-block: stale index falls back to 0
	task automatic test_index_beyond();
		apply_setting(1'b0, 2'd2, 17'd16384, 16'd22938);
		send_pair(1'b1, 32'd16000, 24'h050000, 24'hfb0000);
		apply_setting(1'b0, 2'd2, 17'd4, 16'd22938);
		send_pair(1'b0, 32'd0, 24'h060000, 24'hfa0000);
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_output_backpressure();
		int saved_src;
		saved_src = src_idle_pct;
		apply_setting(1'b0, 2'd2, 17'd16384, 16'd22938);
		src_idle_pct = 0;
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < 24; i++)
			send_pair(i == 0, rand_start_frame(), rand_sample(), rand_sample());
		src_idle_pct = saved_src;
		drain_block();
	endtask

	// runs of well-formed blocks, with stray block starts and missing ones
	task automatic test_random_blocks(input int src_pct, input int snk_pct, input int n_items);
		int   sent;
		int   run_len;
		logic first;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		sent = 0;
		while (sent < n_items) begin
			choose_random_setting();
			run_len = $urandom_range(4, 40);
			for (int i = 0; i < run_len; i++) begin
				if (i == 0)
					first = ($urandom_range(99) < 85);
				else
					first = ($urandom_range(99) < 5);
				send_pair(first, rand_start_frame(), rand_sample(), rand_sample());
				sent++;
			end
		end
		drain_block();
	endtask

	// receiver: random ready, or a long hold when requested
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ch.ready = 1'b0;
				hold_left--;
			end else begin
				out_ch.ready = ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// compare each write transfer with the oldest prediction
	always @(posedge clk) begin : check_writes
		pcm_write_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_writes.size() == 0) begin
				report_mismatch($sformatf("write with nothing pending: addr %0d pcm %h",
					out_ch.write_address, out_ch.pcm_value));
			end else begin
				want = pending_writes.pop_front();
				writes_checked++;
				if (out_ch.write_address !== want.addr)
					report_mismatch($sformatf("write_address %0d, expected %0d",
						out_ch.write_address, want.addr));
				if (out_ch.pcm_value !== want.pcm)
					report_mismatch($sformatf("pcm_value %h, expected %h at addr %0d",
						out_ch.pcm_value, want.pcm, want.addr));
				if (out_ch.last_of_item !== want.last)
					report_mismatch($sformatf("last_of_item %b, expected %b at addr %0d",
						out_ch.last_of_item, want.last, want.addr));
			end
		end
	end

	// cycles since the last transfer on either channel
	always @(posedge clk) begin
		if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
			|| (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("%0t ns: no transfer for %0d cycles", $realtime, STALL_LIMIT);
		$display("FAIL sample_volume_pack_ring_writer");
		$finish;
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SAMPLE_WIDTH_MODE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.first_of_block = 1'b0;
		in_ch.start_frame = '0;
		in_ch.left_sample = '0;
		in_ch.right_sample = '0;
		cur_width_mode = RST_WIDTH_MODE;
		cur_channels = RST_CHANNELS;
		cur_frames = RST_FRAMES;
		cur_gain = RST_GAIN;
		ring_pos = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		src_idle_pct = 37;
		snk_idle_pct = 53;
		test_reset_defaults();
		test_pcm16_gain();
		test_pcm8();
		test_mono();
		test_odd_channels();
		test_frame_clamp();
		test_index_beyond();
		test_output_backpressure();

		test_random_blocks(37, 53, 400);
		test_random_blocks(53, 37, 400);
		test_random_blocks(0, 0, 400);

		drain_block();
		repeat (END_PAUSE) @(negedge clk);

		$display("Sent %0d sample pairs, checked %0d ring writes over %0d register settings.",
			items_sent, writes_checked, settings_applied);
		$display("Covered 8/16-bit saturation, mono/stereo, frame clamping, wraps, long stall.");
		if (mismatches == 0 && pending_writes.size() == 0) begin
			$display("PASS sample_volume_pack_ring_writer");
		end else begin
			$display("%0d mismatches, %0d writes never seen", mismatches, pending_writes.size());
			$display("FAIL sample_volume_pack_ring_writer");
		end
		$finish;
	end

endmodule
